>>> rtl/core/dpid_pkg.sv
// Shared types and constants of the differential-drive PID controller.
// Used by dpid_mac, dpid_div and differential_drive_pid_controller.
// No dependencies.
package dpid_pkg;

	// Default values of the top-level parameters.
	localparam int DEF_MAX_PWM      = 1024;
	localparam int DEF_TICK_RATE_HZ = 1000;
	localparam int DEF_CELL_SIZE_MM = 180;

	// Channel count and datapath widths.
	localparam int NUM_CH = 6;
	localparam int CH_W   = 3;
	localparam int GAIN_W = 16;
	localparam int ERR_W  = 20;
	localparam int SUM_W  = 40;
	localparam int OPB_W  = 41;
	localparam int ACC_W  = 60;

	// Saturation limits of the integral sum, one bit wider than the sum.
	localparam logic signed [SUM_W:0] SUM_MAX = {2'b00, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W:0] SUM_MIN = {2'b11, {(SUM_W-1){1'b0}}};

	// Register indexes on the configuration port.
	localparam logic [2:0] REG_GAINS_LINEAR   = 3'd0;
	localparam logic [2:0] REG_GAINS_ANGULAR  = 3'd1;
	localparam logic [2:0] REG_GAINS_SIDE     = 3'd2;
	localparam logic [2:0] REG_GAINS_FRONT_AN = 3'd3;
	localparam logic [2:0] REG_GAINS_FRONT_DI = 3'd4;
	localparam logic [2:0] REG_GAINS_DIAGONAL = 3'd5;
	localparam logic [2:0] REG_RAMP           = 3'd6;

	// Channel codes, in processing order.
	localparam logic [CH_W-1:0] CH_LINEAR    = 3'd0;
	localparam logic [CH_W-1:0] CH_ANGULAR   = 3'd1;
	localparam logic [CH_W-1:0] CH_SIDE      = 3'd2;
	localparam logic [CH_W-1:0] CH_FRONT_AN  = 3'd3;
	localparam logic [CH_W-1:0] CH_FRONT_DI  = 3'd4;
	localparam logic [CH_W-1:0] CH_DIAGONAL  = 3'd5;

	// PID term codes.
	localparam logic [1:0] TERM_P = 2'd0;
	localparam logic [1:0] TERM_I = 2'd1;
	localparam logic [1:0] TERM_D = 2'd2;

	// Control of the shared multiply-accumulate unit.
	typedef struct packed {
		logic mul_en;
		logic acc_en;
		logic clr;
	} mac_ctrl_t;

endpackage

>>> rtl/core/dpid_mac.sv
// Shared multiply-accumulate unit: registered product, then accumulation.
// Depends on dpid_pkg.
module dpid_mac import dpid_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  mac_ctrl_t                ctrl,
	input  logic signed [GAIN_W-1:0] op_a,
	input  logic signed [OPB_W-1:0]  op_b,
	output logic signed [ACC_W-1:0]  acc
);

	logic signed [GAIN_W+OPB_W-1:0] prod_q;
	logic signed [ACC_W-1:0]        acc_q;

	// Product register, one operand pair per cycle while mul_en is high.
	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			prod_q <= op_a * op_b;
		end
	end

	// Accumulator takes the product of the previous cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctrl.clr) begin
			acc_q <= '0;
		end else if (ctrl.acc_en) begin
			acc_q <= acc_q + ACC_W'(prod_q);
		end
	end

	assign acc = acc_q;

endmodule

>>> rtl/core/dpid_div.sv
// Restoring divider, one quotient bit per cycle, for a bounded quotient.
// Depends on dpid_pkg only through the common import style.
module dpid_div import dpid_pkg::*; #(
	parameter int DVW = 42,
	parameter int DSW = 24,
	parameter int QW  = 15
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [DVW-1:0] dividend,
	input  logic [DSW-1:0] divisor,
	output logic           busy,
	output logic           done,
	output logic [QW-1:0]  quotient
);

	localparam int CNT_W = $clog2(QW + 1);

	logic [DSW-1:0]   rem_q;
	logic [DSW-1:0]   dvs_q;
	logic [QW-1:0]    quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DSW:0]     trial;
	logic             ge;

	// Trial subtraction of the divisor from the shifted remainder.
	assign trial = {rem_q, quo_q[QW-1]};
	assign ge    = trial >= {1'b0, dvs_q};

	// Data path: the low dividend bits shift out as quotient bits shift in.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DSW'(dividend >> QW);
			quo_q <= dividend[QW-1:0];
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? DSW'(trial - {1'b0, dvs_q}) : trial[DSW-1:0];
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

	// Step counter and status.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CNT_W'(QW);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

>>> rtl/core/differential_drive_pid_controller.sv
// Differential-drive PID controller. One input transaction is one control tick: the
// linear speed is ramped, six gated PID channels run on one shared multiply-accumulate
// unit, and the mixed left and right voltages are scaled to PWM by one shared
// iterative divider with QW = max(15, clog2(MAX_PWM+1)+1) quotient bits. A tick passes
// through the ramp division, the channels in turn on the multiplier, one PWM division
// per side, the presentation of the result and the return to idle. The ramp at its
// target skips the ramp division, a side that saturates outright skips its PWM
// division, and a tick with the run flag low clears the ramp and loops and reports zeros.
// The input is not ready while a tick is in work; a finished result waits in an output
// register, and a stalled output holds the next result back. Depends on dpid_pkg,
// dpid_mac, dpid_div.
module differential_drive_pid_controller import dpid_pkg::*; #(
	parameter int MAX_PWM      = DEF_MAX_PWM,
	parameter int TICK_RATE_HZ = DEF_TICK_RATE_HZ,
	parameter int CELL_SIZE_MM = DEF_CELL_SIZE_MM
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// mode_flags[6:0], target_speed[22:7], ideal_turn_rate[38:23],
	// wheel_speed_left[54:39], wheel_speed_right[70:55], gyro_rate[86:71],
	// side_error[102:87], front_angle_error[118:103], diag_err[134:119],
	// wall_distance[150:135], wanted_wall_distance[165:151], battery_mv[181:166]
	input  logic [183:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// drive_left[11:0], drive_right[23:12], ramped_speed[39:24], drive_clipped[40]
	output logic [47:0]  m_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [5:0]   paddr,
	input  logic [63:0]  pwdata,
	output logic [63:0]  prdata,
	output logic         pready
);

	localparam int MPW = $clog2(MAX_PWM + 1);
	localparam int QW  = (MPW + 1 > 15) ? MPW + 1 : 15;
	localparam int DSW = ($clog2(TICK_RATE_HZ + 1) > 24) ? $clog2(TICK_RATE_HZ + 1) : 24;
	localparam int DVW = 25 + MPW;

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_RAMP    = 4'd1;
	localparam logic [3:0] S_RAMP_W  = 4'd2;
	localparam logic [3:0] S_CH      = 4'd3;
	localparam logic [3:0] S_CH_ACC  = 4'd4;
	localparam logic [3:0] S_CH_END  = 4'd5;
	localparam logic [3:0] S_PWM     = 4'd6;
	localparam logic [3:0] S_PWM_DIV = 4'd7;
	localparam logic [3:0] S_PWM_W   = 4'd8;
	localparam logic [3:0] S_DONE    = 4'd9;

	// Configuration registers.
	logic [47:0] gains_q [NUM_CH];
	logic [59:0] ramp_cfg_q;

	// Sequencer and working state.
	logic [3:0]      state_q;
	logic [CH_W-1:0] ch_q;
	logic [1:0]      term_q;
	logic            side_q;
	logic            up_q;
	logic [183:0]    din_q;

	logic signed [15:0]      ramp_q;
	logic signed [ERR_W-1:0] prev_q [NUM_CH];
	logic signed [SUM_W-1:0] sum_q  [NUM_CH];
	logic signed [ACC_W-1:0] lin_q;
	logic signed [ACC_W-1:0] ang_q;
	logic signed [ACC_W:0]   v_q;
	logic [11:0]             res_l_q;
	logic [11:0]             res_r_q;
	logic                    clip_q;
	logic                    m_tvalid_q;
	logic [47:0]             m_tdata_q;

	// Fields of the latched tick.
	logic [6:0]         mode;
	logic signed [15:0] target;
	logic signed [15:0] turn;
	logic signed [15:0] whl_l;
	logic signed [15:0] whl_r;
	logic signed [15:0] gyro;
	logic signed [15:0] side_err;
	logic signed [15:0] fa_err;
	logic signed [15:0] diag_err;
	logic [15:0]        wall;
	logic [14:0]        wanted;
	logic [15:0]        batt;
	logic [15:0]        batt_eff;

	assign mode     = din_q[6:0];
	assign target   = $signed(din_q[22:7]);
	assign turn     = $signed(din_q[38:23]);
	assign whl_l    = $signed(din_q[54:39]);
	assign whl_r    = $signed(din_q[70:55]);
	assign gyro     = $signed(din_q[86:71]);
	assign side_err = $signed(din_q[102:87]);
	assign fa_err   = $signed(din_q[118:103]);
	assign diag_err = $signed(din_q[134:119]);
	assign wall     = din_q[150:135];
	assign wanted   = din_q[165:151];
	assign batt     = din_q[181:166];
	assign batt_eff = (batt == 16'd0) ? 16'd1 : batt;

	logic in_fire;
	logic cfg_wr;
	assign in_fire = s_tvalid && s_tready;
	assign cfg_wr  = psel && penable && pwrite && pready;

	// Configuration writes and reads.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CH; i++) begin
				gains_q[i] <= '0;
			end
			ramp_cfg_q <= '0;
		end else if (cfg_wr) begin
			if (paddr[5:3] == REG_RAMP) begin
				ramp_cfg_q <= pwdata[59:0];
			end else if (paddr[5:3] < REG_RAMP) begin
				gains_q[paddr[5:3]] <= pwdata[47:0];
			end
		end
	end

	always_comb begin
		case (paddr[5:3])
			REG_GAINS_LINEAR:   prdata = {16'd0, gains_q[CH_LINEAR]};
			REG_GAINS_ANGULAR:  prdata = {16'd0, gains_q[CH_ANGULAR]};
			REG_GAINS_SIDE:     prdata = {16'd0, gains_q[CH_SIDE]};
			REG_GAINS_FRONT_AN: prdata = {16'd0, gains_q[CH_FRONT_AN]};
			REG_GAINS_FRONT_DI: prdata = {16'd0, gains_q[CH_FRONT_DI]};
			REG_GAINS_DIAGONAL: prdata = {16'd0, gains_q[CH_DIAGONAL]};
			REG_RAMP:           prdata = {4'd0, ramp_cfg_q};
			default:            prdata = '0;
		endcase
	end

	assign pready = 1'b1;

	// Ramp acceleration choice.
	logic [14:0] soft_acc;
	logic [14:0] hard_acc;
	logic [14:0] knee;
	logic [14:0] brake_acc;
	logic        ramp_up;
	logic        below_knee;
	logic [14:0] accel;

	assign soft_acc   = ramp_cfg_q[14:0];
	assign hard_acc   = ramp_cfg_q[29:15];
	assign knee       = ramp_cfg_q[44:30];
	assign brake_acc  = ramp_cfg_q[59:45];
	assign ramp_up    = ramp_q < target;
	assign below_knee = 17'(ramp_q) < $signed({2'b00, knee});
	assign accel      = ramp_up ? (((knee == 15'd0) || below_knee) ? hard_acc : soft_acc)
	                            : brake_acc;

	// Shared divider.
	logic           div_start;
	logic [DVW-1:0] div_dividend;
	logic [DSW-1:0] div_divisor;
	logic           div_busy;
	logic           div_done;
	logic [QW-1:0]  div_quot;

	// Magnitude of the voltage being scaled and the outright saturation test.
	logic [ACC_W:0] mag;
	logic           big;
	assign mag = v_q[ACC_W] ? (ACC_W+1)'(-v_q) : v_q;
	assign big = mag >= (ACC_W+1)'({batt_eff, 9'd0});

	always_comb begin
		if (state_q == S_RAMP) begin
			div_dividend = DVW'(accel);
			div_divisor  = DSW'(TICK_RATE_HZ);
		end else begin
			div_dividend = DVW'(mag[24:0]) * DVW'(MAX_PWM);
			div_divisor  = DSW'({batt_eff, 8'd0});
		end
	end

	assign div_start = ((state_q == S_RAMP) && (ramp_q != target)) ||
	                   ((state_q == S_PWM_DIV) && !big);

	dpid_div #(
		.DVW (DVW),
		.DSW (DSW),
		.QW  (QW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quot)
	);

	// Ramp step after the division, clamped at the target.
	logic signed [17:0] ramp_step;
	logic signed [17:0] ramp_new;
	logic signed [15:0] ramp_next;
	assign ramp_step = $signed({3'b000, div_quot[14:0]});
	assign ramp_new  = up_q ? 18'(ramp_q) + ramp_step : 18'(ramp_q) - ramp_step;
	always_comb begin
		if (up_q && (ramp_new > 18'(target))) begin
			ramp_next = target;
		end else if (!up_q && (ramp_new < 18'(target))) begin
			ramp_next = target;
		end else begin
			ramp_next = ramp_new[15:0];
		end
	end

	// Error and gate of the current channel.
	logic signed [ERR_W-1:0] e_cur;
	logic                    on_cur;
	always_comb begin
		case (ch_q)
			CH_LINEAR: begin
				e_cur  = (ERR_W'(ramp_q) <<< 1) - (ERR_W'(whl_l) + ERR_W'(whl_r));
				on_cur = mode[1];
			end
			CH_ANGULAR: begin
				e_cur  = ERR_W'(turn) + ERR_W'(gyro);
				on_cur = mode[2];
			end
			CH_SIDE: begin
				e_cur  = ERR_W'(side_err);
				on_cur = mode[3];
			end
			CH_FRONT_AN: begin
				e_cur  = ERR_W'(fa_err);
				on_cur = mode[4];
			end
			CH_FRONT_DI: begin
				e_cur  = $signed(ERR_W'(wall)) - $signed(ERR_W'(wanted));
				on_cur = mode[5] && (wanted != 15'd0) && (32'(wall) < CELL_SIZE_MM);
			end
			CH_DIAGONAL: begin
				e_cur  = ERR_W'(diag_err);
				on_cur = mode[6];
			end
			default: begin
				e_cur  = '0;
				on_cur = 1'b0;
			end
		endcase
	end

	// Saturated integral and difference terms.
	logic signed [SUM_W:0]   s_wide;
	logic signed [SUM_W-1:0] s_sat;
	logic signed [ERR_W:0]   d_cur;
	assign s_wide = (SUM_W+1)'(sum_q[ch_q]) + (SUM_W+1)'(e_cur);
	assign d_cur  = (ERR_W+1)'(e_cur) - (ERR_W+1)'(prev_q[ch_q]);
	always_comb begin
		if (s_wide > SUM_MAX) begin
			s_sat = SUM_MAX[SUM_W-1:0];
		end else if (s_wide < SUM_MIN) begin
			s_sat = SUM_MIN[SUM_W-1:0];
		end else begin
			s_sat = s_wide[SUM_W-1:0];
		end
	end

	// Operand selection for the shared multiply-accumulate unit.
	logic signed [GAIN_W-1:0] op_a;
	logic signed [OPB_W-1:0]  op_b;
	logic [47:0]              g_cur;
	mac_ctrl_t                mac_ctrl;
	logic signed [ACC_W-1:0]  mac_acc;

	assign g_cur = gains_q[ch_q];
	always_comb begin
		case (term_q)
			TERM_P: begin
				op_a = $signed(g_cur[15:0]);
				op_b = OPB_W'(e_cur);
			end
			TERM_I: begin
				op_a = $signed(g_cur[31:16]);
				op_b = OPB_W'(s_sat);
			end
			TERM_D: begin
				op_a = $signed(g_cur[47:32]);
				op_b = OPB_W'(d_cur);
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
		if (!on_cur) begin
			op_b = '0;
		end
	end

	assign mac_ctrl.mul_en = (state_q == S_CH);
	assign mac_ctrl.acc_en = ((state_q == S_CH) && (term_q != TERM_P)) ||
	                         (state_q == S_CH_ACC);
	assign mac_ctrl.clr    = (state_q == S_RAMP) || (state_q == S_RAMP_W) ||
	                         (state_q == S_CH_END);

	dpid_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.op_a   (op_a),
		.op_b   (op_b),
		.acc    (mac_acc)
	);

	// PWM magnitude, sign and saturation flag of the side being finished.
	logic              q_over;
	logic [QW-1:0]     pwm_mag;
	logic signed [QW:0] pwm_val;
	logic              pwm_clip;
	logic              pwm_wr;
	assign q_over   = div_quot > QW'(MAX_PWM);
	assign pwm_mag  = ((state_q == S_PWM_DIV) || q_over) ? QW'(MAX_PWM) : div_quot;
	assign pwm_val  = v_q[ACC_W] ? -$signed({1'b0, pwm_mag}) : $signed({1'b0, pwm_mag});
	assign pwm_clip = (state_q == S_PWM_DIV) || q_over;
	assign pwm_wr   = ((state_q == S_PWM_DIV) && big) || ((state_q == S_PWM_W) && div_done);

	logic out_free;
	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == S_IDLE);

	// Tick latch (payload only) and the mixed voltage of the side being scaled.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			din_q <= s_tdata;
		end
		if (state_q == S_PWM) begin
			v_q <= side_q ? (ACC_W+1)'(lin_q) - (ACC_W+1)'(ang_q)
			              : (ACC_W+1)'(lin_q) + (ACC_W+1)'(ang_q);
		end
	end

	// Sequencer and controller state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ch_q    <= '0;
			term_q  <= TERM_P;
			side_q  <= 1'b0;
			up_q    <= 1'b0;
			ramp_q  <= '0;
			lin_q   <= '0;
			ang_q   <= '0;
			res_l_q <= '0;
			res_r_q <= '0;
			clip_q  <= 1'b0;
			for (int i = 0; i < NUM_CH; i++) begin
				prev_q[i] <= '0;
				sum_q[i]  <= '0;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						if (!s_tdata[0]) begin
							// Run flag low: clear the ramp, the loops and the results and report zeros.
							ramp_q  <= '0;
							res_l_q <= '0;
							res_r_q <= '0;
							clip_q  <= 1'b0;
							for (int i = 0; i < NUM_CH; i++) begin
								prev_q[i] <= '0;
								sum_q[i]  <= '0;
							end
							state_q <= S_DONE;
						end else begin
							state_q <= S_RAMP;
						end
					end
				end
				S_RAMP: begin
					ch_q   <= '0;
					term_q <= TERM_P;
					side_q <= 1'b0;
					lin_q  <= '0;
					ang_q  <= '0;
					clip_q <= 1'b0;
					up_q   <= ramp_up;
					state_q <= (ramp_q != target) ? S_RAMP_W : S_CH;
				end
				S_RAMP_W: begin
					if (div_done) begin
						ramp_q  <= ramp_next;
						state_q <= S_CH;
					end
				end
				S_CH: begin
					term_q <= term_q + 2'd1;
					if (term_q == TERM_D) begin
						state_q <= S_CH_ACC;
					end
				end
				S_CH_ACC: begin
					state_q <= S_CH_END;
				end
				S_CH_END: begin
					// Fold the channel into the linear or angular voltage.
					case (ch_q)
						CH_LINEAR:   lin_q <= lin_q + (mac_acc >>> 1);
						CH_ANGULAR:  ang_q <= ang_q + (mac_acc >>> 11);
						CH_FRONT_DI: lin_q <= lin_q + mac_acc;
						default:     ang_q <= ang_q + mac_acc;
					endcase
					prev_q[ch_q] <= on_cur ? e_cur : '0;
					sum_q[ch_q]  <= on_cur ? s_sat : '0;
					term_q <= TERM_P;
					if (ch_q == CH_DIAGONAL) begin
						state_q <= S_PWM;
					end else begin
						ch_q    <= ch_q + 1'b1;
						state_q <= S_CH;
					end
				end
				S_PWM: begin
					state_q <= S_PWM_DIV;
				end
				S_PWM_DIV: begin
					state_q <= big ? (side_q ? S_DONE : S_PWM) : S_PWM_W;
					if (big) begin
						side_q <= 1'b1;
					end
				end
				S_PWM_W: begin
					if (div_done) begin
						side_q  <= 1'b1;
						state_q <= side_q ? S_DONE : S_PWM;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			// Store one side's PWM result.
			if (pwm_wr) begin
				if (side_q) begin
					res_r_q <= pwm_val[11:0];
				end else begin
					res_l_q <= pwm_val[11:0];
				end
				clip_q <= clip_q | pwm_clip;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if ((state_q == S_DONE) && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && out_free) begin
			m_tdata_q <= {7'd0, clip_q, ramp_q, res_r_q, res_l_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`ifndef NO_ASSERTIONS
	// A new tick is never taken while the divider is still iterating.
	a_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !div_busy) else $error("tick accepted with divider busy");

	// The divider only finishes while the sequencer waits for it.
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> ((state_q == S_RAMP_W) || (state_q == S_PWM_W)))
		else $error("divider result with no waiting state");

	// Leaving the done state always presents a result.
	a_done_out: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_DONE) && out_free) |=> m_tvalid)
		else $error("result not presented");

	// Multiplier is only used while a channel is in work.
	a_mac_use: assert property (@(posedge clk) disable iff (!arst_n)
		mac_ctrl.mul_en |-> (ch_q <= CH_DIAGONAL))
		else $error("multiplier used outside channel range");
`endif

endmodule

>>> test/dpid_checker.sv
// Checker for the differential-drive PID controller: watches the configuration port and
// both stream channels, predicts each tick's drive outputs and compares them.
// Depends on dpid_pkg for the register indexes and channel codes.
`timescale 1ns / 1ps

module dpid_checker import dpid_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [183:0] s_tdata,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [47:0]  m_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [5:0]   paddr,
	input  logic [63:0]  pwdata,
	input  logic         pready,
	output int           fails,
	output int           pending
);

	localparam longint PWM_LIMIT  = 1024;
	localparam longint TICK_HZ    = 1000;
	localparam longint CELL_MM    = 180;
	localparam longint ACC_LIMIT  = 64'sd549755813887;

	typedef struct {
		logic signed [11:0] left;
		logic signed [11:0] right;
		logic signed [15:0] speed;
		logic               clip;
	} drive_t;

	logic [63:0] gain_regs [0:NUM_CH-1];
	logic [59:0] ramp_reg;
	longint      ramp_now;
	longint      prev_err [0:NUM_CH-1];
	longint      err_acc  [0:NUM_CH-1];
	drive_t      drive_q [$];

	// Clears the controller state, as on a tick with the run flag low.
	function automatic void clear_loops();
		ramp_now = 0;
		for (int i = 0; i < NUM_CH; i++) begin
			prev_err[i] = 0;
			err_acc[i]  = 0;
		end
	endfunction

	// One gated PID channel; returns the raw sum in the channel's own scale.
	function automatic longint pid_term(input int ch, input bit on, input longint e);
		longint kp, ki, kd, s, d;
		kp = longint'($signed(gain_regs[ch][15:0]));
		ki = longint'($signed(gain_regs[ch][31:16]));
		kd = longint'($signed(gain_regs[ch][47:32]));
		if (!on) begin
			prev_err[ch] = 0;
			err_acc[ch]  = 0;
			return 0;
		end
		s = err_acc[ch] + e;
		if (s > ACC_LIMIT) s = ACC_LIMIT;
		if (s < -ACC_LIMIT - 1) s = -ACC_LIMIT - 1;
		err_acc[ch] = s;
		d = e - prev_err[ch];
		prev_err[ch] = longint'(int'(e));
		return kp * e + ki * s + kd * d;
	endfunction

	// Scales a Q.8 millivolt value to PWM and saturates it.
	function automatic longint volts_to_pwm(input longint v, input longint batt,
			inout logic clip);
		longint mag, p;
		mag = (v < 0) ? -v : v;
		if (mag >= 512 * batt) begin
			clip = 1'b1;
			return (v < 0) ? -PWM_LIMIT : PWM_LIMIT;
		end
		p = (v * PWM_LIMIT) / (256 * batt);
		if (p > PWM_LIMIT) begin
			clip = 1'b1;
			return PWM_LIMIT;
		end
		if (p < -PWM_LIMIT) begin
			clip = 1'b1;
			return -PWM_LIMIT;
		end
		return p;
	endfunction

	// Works out the result of one tick and advances the state.
	function automatic drive_t predict_tick(input logic [183:0] d);
		drive_t r;
		logic [6:0] mode;
		longint target, acc, e, lin, ang, wall, wanted, batt, lv, rv;
		longint soft_a, hard_a, knee, brake;
		logic clip;
		mode = d[6:0];
		clip = 1'b0;
		if (!mode[0]) begin
			clear_loops();
			r.left = '0; r.right = '0; r.speed = '0; r.clip = 1'b0;
			return r;
		end
		// Speed ramp towards the target.
		target = longint'($signed(d[22:7]));
		soft_a = ramp_reg[14:0];
		hard_a = ramp_reg[29:15];
		knee   = ramp_reg[44:30];
		brake  = ramp_reg[59:45];
		if (ramp_now < target) begin
			acc = (knee == 0 || ramp_now < knee) ? hard_a : soft_a;
			ramp_now = ramp_now + acc / TICK_HZ;
			if (ramp_now > target) ramp_now = target;
		end else if (ramp_now > target) begin
			ramp_now = ramp_now - brake / TICK_HZ;
			if (ramp_now < target) ramp_now = target;
		end
		e = 2 * ramp_now - (longint'($signed(d[54:39])) + longint'($signed(d[70:55])));
		lin = pid_term(CH_LINEAR, mode[1], e) >>> 1;
		e = longint'($signed(d[38:23])) + longint'($signed(d[86:71]));
		ang = pid_term(CH_ANGULAR, mode[2], e) >>> 11;
		ang += pid_term(CH_SIDE, mode[3], longint'($signed(d[102:87])));
		ang += pid_term(CH_FRONT_AN, mode[4], longint'($signed(d[118:103])));
		wall   = d[150:135];
		wanted = d[165:151];
		lin += pid_term(CH_FRONT_DI, mode[5] && wanted > 0 && wall < CELL_MM, wall - wanted);
		ang += pid_term(CH_DIAGONAL, mode[6], longint'($signed(d[134:119])));
		batt = d[181:166];
		if (batt == 0) batt = 1;
		lv = volts_to_pwm(lin + ang, batt, clip);
		rv = volts_to_pwm(lin - ang, batt, clip);
		r.left  = lv[11:0];
		r.right = rv[11:0];
		r.speed = ramp_now[15:0];
		r.clip  = clip;
		return r;
	endfunction

	assign pending = drive_q.size();

	// Results are matched before new ticks are predicted, as they belong to older ticks.
	always @(posedge clk or negedge arst_n) begin
		drive_t want;
		if (!arst_n) begin
			for (int i = 0; i < NUM_CH; i++) gain_regs[i] = '0;
			ramp_reg = '0;
			clear_loops();
			drive_q.delete();
			fails = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (drive_q.size() == 0) begin
					$error("drive result with no tick waiting: %h", m_tdata);
					fails++;
				end else begin
					want = drive_q.pop_front();
					if (m_tdata[11:0] !== want.left) begin
						$error("drive_left expected %0d got %0d", want.left,
							$signed(m_tdata[11:0]));
						fails++;
					end
					if (m_tdata[23:12] !== want.right) begin
						$error("drive_right expected %0d got %0d", want.right,
							$signed(m_tdata[23:12]));
						fails++;
					end
					if (m_tdata[39:24] !== want.speed) begin
						$error("ramped_speed expected %0d got %0d", want.speed,
							$signed(m_tdata[39:24]));
						fails++;
					end
					if (m_tdata[40] !== want.clip) begin
						$error("drive_clipped expected %0b got %0b", want.clip, m_tdata[40]);
						fails++;
					end
				end
			end
			if (psel && penable && pwrite && pready) begin
				if (paddr[5:3] == REG_RAMP) ramp_reg = pwdata[59:0];
				else if (paddr[5:3] < REG_RAMP) gain_regs[paddr[5:3]] = {16'h0, pwdata[47:0]};
			end
			if (s_tvalid && s_tready) drive_q.push_back(predict_tick(s_tdata));
		end
	end

endmodule

>>> test/tb_top.sv
// Testbench top of the differential-drive PID controller: drives ticks and register
// writes, stalls the result channel at random and gives the verdict.
// Depends on dpid_pkg, the controller and dpid_checker.
`timescale 1ns / 1ps

module tb_top import dpid_pkg::*; ;

	localparam int TICKS_PER_PHASE = 190;
	localparam int PHASES          = 6;
	localparam int IDLE_LIMIT      = 20000;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	// mode_flags, target_speed, ideal_turn_rate, wheel speeds, gyro_rate, sensor errors,
	// wall_distance, wanted_wall_distance, battery_mv, from the lowest bit up
	logic [183:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	// drive_left, drive_right, ramped_speed, drive_clipped, from the lowest bit up
	logic [47:0]  m_tdata;
	logic         psel, penable, pwrite, pready;
	logic [5:0]   paddr;
	logic [63:0]  pwdata, prdata;
	int           fails, pending;
	int           idle_cycles;
	int           result_count;

	differential_drive_pid_controller u_dut (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
	);

	dpid_checker u_checker (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata,
		.psel, .penable, .pwrite, .paddr, .pwdata, .pready, .fails, .pending
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Packs one tick into the stream word.
	function automatic logic [183:0] pack_tick(input logic [6:0] mode, input logic [15:0] tgt,
			input logic [15:0] turn, input logic [15:0] wl, input logic [15:0] wr,
			input logic [15:0] gyro, input logic [15:0] side, input logic [15:0] fang,
			input logic [15:0] diag, input logic [15:0] wall, input logic [14:0] wanted,
			input logic [15:0] batt);
		return {2'b00, batt, wanted, wall, diag, fang, side, gyro, wr, wl, turn, tgt, mode};
	endfunction

	function automatic logic [15:0] rnd16();
		return 16'($urandom_range(0, 65535));
	endfunction

	// A signed value near zero, so that the loops stay out of saturation.
	function automatic logic [15:0] near_zero(input int span);
		return 16'($urandom_range(0, 2 * span) - span);
	endfunction

	// Random tick: mostly running with modest values, some fully random, some stopped.
	function automatic logic [183:0] random_tick();
		logic [6:0] mode;
		int pick;
		pick = $urandom_range(0, 99);
		mode = 7'($urandom_range(0, 127));
		if (pick < 8) mode[0] = 1'b0;
		else mode[0] = 1'b1;
		if (pick >= 80)
			return pack_tick(mode, rnd16(), rnd16(), rnd16(), rnd16(), rnd16(), rnd16(),
				rnd16(), rnd16(), rnd16(), 15'($urandom_range(0, 32767)), rnd16());
		return pack_tick(mode, near_zero(1500), near_zero(3000), near_zero(1500),
			near_zero(1500), near_zero(3000), near_zero(300), near_zero(300), near_zero(300),
			16'($urandom_range(0, 260)), 15'($urandom_range(0, 200)),
			16'($urandom_range(6000, 8500)));
	endfunction

	// Gains word: either small signed Q8.8 terms or all bits random.
	function automatic logic [63:0] random_gains(input bit wild);
		if (wild) return {16'h0, rnd16(), rnd16(), rnd16()};
		return {16'h0, near_zero(256), near_zero(64), near_zero(512)};
	endfunction

	task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic send_tick(input logic [183:0] word);
		int gap;
		gap = $urandom_range(0, 13);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= word;
		do @(posedge clk); while (!s_tready);
	endtask

	// Waits for every outstanding result, then lets the block settle.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic program_all(input int style);
		logic [63:0] ramp;
		for (int i = 0; i < NUM_CH; i++) begin
			case (style)
				0: reg_write(3'(i), 64'h0000_FFFF_FFFF_FFFF);
				1: reg_write(3'(i), 64'h0000_8000_8000_8000);
				2: reg_write(3'(i), 64'h0);
				default: reg_write(3'(i), random_gains(style == 3));
			endcase
		end
		case (style)
			0: ramp = 60'hFFF_FFFF_FFFF_FFFF;
			2: ramp = 64'h0;
			4: ramp = {15'($urandom_range(0, 32767)), 15'd0, 15'($urandom_range(0, 32767)),
				15'($urandom_range(0, 32767))};
			default: ramp = {4'h0, 15'($urandom_range(1000, 32767)),
				15'($urandom_range(0, 1200)), 15'($urandom_range(1000, 32767)),
				15'($urandom_range(1000, 32767))};
		endcase
		reg_write(REG_RAMP, ramp);
	endtask

	// Result side: random stalls, with one long hold while ticks keep coming.
	initial begin
		int stall;
		m_tready <= 1'b0;
		result_count = 0;
		@(posedge arst_n);
		forever begin
			stall = $urandom_range(0, 13);
			if (result_count % 300 < 40) stall = 0;
			if (result_count == 400) stall = 900;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			result_count++;
		end
	end

	// Watchdog on cycles in which no transaction of any kind completes.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		idle_cycles = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed ticks under fully random gains and a knee-free ramp.
		program_all(3);
		reg_write(REG_RAMP, {15'd20000, 15'd0, 15'd30000, 15'd8000});
		send_tick(pack_tick(7'h00, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
			16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 15'h7FFF, 16'hFFFF));
		for (int ch = 0; ch < 7; ch++)
			send_tick(pack_tick(7'(1 | (ch > 0 ? (1 << ch) : 0)), 16'd1000, 16'd2000,
				16'd100, 16'd120, 16'hFF00, 16'd50, 16'hFFC0, 16'd70, 16'd100, 15'd90, 16'd7400));
		send_tick(pack_tick(7'h7F, 16'd500, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
			16'd0, 16'd180, 15'd90, 16'd7400));
		send_tick(pack_tick(7'h7F, 16'd500, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
			16'd0, 16'd179, 15'd0, 16'd7400));
		send_tick(pack_tick(7'h7F, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
			16'h8000, 16'h8000, 16'h8000, 16'd0, 15'd1, 16'd0));
		send_tick(pack_tick(7'h7F, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
			16'h7FFF, 16'h7FFF, 16'h7FFF, 16'd10, 15'h7FFF, 16'd1));
		send_tick(pack_tick(7'h7F, 16'h8000, 16'd5, 16'd3, 16'd3, 16'd5, 16'd1, 16'd1,
			16'd1, 16'd100, 15'd50, 16'hFFFF));
		send_tick(pack_tick(7'h7F, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
			16'd0, 16'd0, 15'd0, 16'hFFFF));
		send_tick(pack_tick(7'h7E, 16'd300, 16'd10, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1,
			16'd1, 16'd1, 15'd1, 16'd7000));
		drain();

		// Random phases over extreme, zero and random settings.
		for (int ph = 0; ph < PHASES; ph++) begin
			program_all(ph == 5 ? 5 : ph);
			for (int n = 0; n < TICKS_PER_PHASE; n++) send_tick(random_tick());
			drain();
		end

		if (fails == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
